// ----- rtl/core/tcr_pkg.sv -----
`timescale 1ns / 1ps
package tcr_pkg;

  localparam int COORD_BITS       = 16;
  localparam int RADIUS_FRAC_BITS = 16;
  localparam int FIELD_W          = 16;
  localparam int RADIUS_W         = 48;

  // edge vectors, squared lengths, cross products, volume term, circumcentre numerator
  localparam int DW   = COORD_BITS + 1;
  localparam int XW   = 2 * DW;
  localparam int SQW  = XW + 1;
  localparam int AW   = DW + XW + 2;
  localparam int MW   = AW + 1;
  localparam int UW   = SQW + XW + 2;
  localparam int LO_W = (UW + 1) / 2;
  localparam int HI_W = UW - LO_W;
  localparam int SQU  = 2 * UW;
  localparam int NW   = SQU + 2;
  localparam int NW2  = NW + 2 * RADIUS_FRAC_BITS;
  localparam int RW   = NW2 / 2;
  localparam int CW   = RW + MW + RADIUS_W;

  localparam int QDEPTH       = 4;
  localparam int QPTR_W       = 2;
  localparam int FRONT_STAGES = 7;

  typedef struct packed {
    logic signed [FIELD_W-1:0] a_x;
    logic signed [FIELD_W-1:0] a_y;
    logic signed [FIELD_W-1:0] a_z;
    logic signed [FIELD_W-1:0] b_x;
    logic signed [FIELD_W-1:0] b_y;
    logic signed [FIELD_W-1:0] b_z;
    logic signed [FIELD_W-1:0] c_x;
    logic signed [FIELD_W-1:0] c_y;
    logic signed [FIELD_W-1:0] c_z;
    logic signed [FIELD_W-1:0] d_x;
    logic signed [FIELD_W-1:0] d_y;
    logic signed [FIELD_W-1:0] d_z;
  } tcr_in_t;

  typedef struct packed {
    logic [RADIUS_W-1:0] radius;
    logic                degenerate;
    logic                saturated;
  } tcr_out_t;

  // squared numerator, twice the volume term and the coplanar mark
  typedef struct packed {
    logic [NW-1:0] n;
    logic [MW-1:0] m;
    logic          deg;
  } tcr_job_t;

endpackage

// ----- rtl/core/tcr_if.sv -----
`timescale 1ns / 1ps
interface tcr_in_if;
  logic             valid;
  logic             ready;
  tcr_pkg::tcr_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tcr_out_if;
  logic              valid;
  logic              ready;
  tcr_pkg::tcr_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/tcr_front.sv -----
`timescale 1ns / 1ps
module tcr_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tcr_pkg::tcr_in_t   in_data_i,
  input  logic               full_i,
  output logic               push_o,
  output tcr_pkg::tcr_job_t  job_o
);
  import tcr_pkg::*;

  function automatic logic signed [DW-1:0] coord_ext(input logic [FIELD_W-1:0] f);
    logic signed [COORD_BITS-1:0] t;
    t = f[COORD_BITS-1:0];
    return DW'(t);
  endfunction

  function automatic logic signed [XW-1:0] mul_dd(input logic signed [DW-1:0] x,
                                                  input logic signed [DW-1:0] y);
    logic signed [XW-1:0] p;
    p = XW'(x) * XW'(y);
    return p;
  endfunction

  function automatic logic signed [AW-1:0] mul_dx(input logic signed [DW-1:0] x,
                                                  input logic signed [XW-1:0] y);
    logic signed [AW-1:0] p;
    p = AW'(x) * AW'(y);
    return p;
  endfunction

  function automatic logic signed [UW-1:0] mul_sx(input logic signed [SQW-1:0] x,
                                                  input logic signed [XW-1:0] y);
    logic signed [UW-1:0] p;
    p = UW'(x) * UW'(y);
    return p;
  endfunction

  logic                    en;
  logic [FRONT_STAGES-1:0] vld_q;

  logic signed [DW-1:0]  b_q [3];
  logic signed [DW-1:0]  c_q [3];
  logic signed [DW-1:0]  d_q [3];

  logic signed [DW-1:0]  b2_q [3];
  logic signed [SQW-1:0] bb_q, cc_q, dd_q;
  logic signed [XW-1:0]  cd_q [3];
  logic signed [XW-1:0]  db_q [3];
  logic signed [XW-1:0]  bc_q [3];

  logic signed [AW-1:0]  a_q;
  logic signed [UW-1:0]  u_q [3];

  logic [UW-1:0]         um_q [3];
  logic [MW-1:0]         m4_q;
  logic                  deg4_q;

  logic [2*HI_W-1:0]     hh_q [3];
  logic [2*LO_W-1:0]     ll_q [3];
  logic [HI_W+LO_W-1:0]  hl_q [3];
  logic [MW-1:0]         m5_q;
  logic                  deg5_q;

  logic [SQU-1:0]        sq_q [3];
  logic [MW-1:0]         m6_q;
  logic                  deg6_q;

  tcr_job_t              job_q;

  logic [AW-1:0]         abs_a;

  assign en         = !full_i;
  assign in_ready_o = en;
  assign push_o     = en & vld_q[FRONT_STAGES-1];
  assign job_o      = job_q;

  assign abs_a = a_q[AW-1] ? (~a_q + 1'b1) : a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[FRONT_STAGES-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // edges relative to the first corner
      b_q[0] <= coord_ext(in_data_i.b_x) - coord_ext(in_data_i.a_x);
      b_q[1] <= coord_ext(in_data_i.b_y) - coord_ext(in_data_i.a_y);
      b_q[2] <= coord_ext(in_data_i.b_z) - coord_ext(in_data_i.a_z);
      c_q[0] <= coord_ext(in_data_i.c_x) - coord_ext(in_data_i.a_x);
      c_q[1] <= coord_ext(in_data_i.c_y) - coord_ext(in_data_i.a_y);
      c_q[2] <= coord_ext(in_data_i.c_z) - coord_ext(in_data_i.a_z);
      d_q[0] <= coord_ext(in_data_i.d_x) - coord_ext(in_data_i.a_x);
      d_q[1] <= coord_ext(in_data_i.d_y) - coord_ext(in_data_i.a_y);
      d_q[2] <= coord_ext(in_data_i.d_z) - coord_ext(in_data_i.a_z);

      b2_q  <= b_q;
      bb_q  <= SQW'(mul_dd(b_q[0], b_q[0])) + SQW'(mul_dd(b_q[1], b_q[1]))
             + SQW'(mul_dd(b_q[2], b_q[2]));
      cc_q  <= SQW'(mul_dd(c_q[0], c_q[0])) + SQW'(mul_dd(c_q[1], c_q[1]))
             + SQW'(mul_dd(c_q[2], c_q[2]));
      dd_q  <= SQW'(mul_dd(d_q[0], d_q[0])) + SQW'(mul_dd(d_q[1], d_q[1]))
             + SQW'(mul_dd(d_q[2], d_q[2]));
      cd_q[0] <= mul_dd(c_q[1], d_q[2]) - mul_dd(c_q[2], d_q[1]);
      cd_q[1] <= mul_dd(c_q[2], d_q[0]) - mul_dd(c_q[0], d_q[2]);
      cd_q[2] <= mul_dd(c_q[0], d_q[1]) - mul_dd(c_q[1], d_q[0]);
      db_q[0] <= mul_dd(d_q[1], b_q[2]) - mul_dd(d_q[2], b_q[1]);
      db_q[1] <= mul_dd(d_q[2], b_q[0]) - mul_dd(d_q[0], b_q[2]);
      db_q[2] <= mul_dd(d_q[0], b_q[1]) - mul_dd(d_q[1], b_q[0]);
      bc_q[0] <= mul_dd(b_q[1], c_q[2]) - mul_dd(b_q[2], c_q[1]);
      bc_q[1] <= mul_dd(b_q[2], c_q[0]) - mul_dd(b_q[0], c_q[2]);
      bc_q[2] <= mul_dd(b_q[0], c_q[1]) - mul_dd(b_q[1], c_q[0]);

      a_q <= mul_dx(b2_q[0], cd_q[0]) + mul_dx(b2_q[1], cd_q[1]) + mul_dx(b2_q[2], cd_q[2]);
      for (int i = 0; i < 3; i++) begin
        u_q[i] <= mul_sx(bb_q, cd_q[i]) + mul_sx(cc_q, db_q[i]) + mul_sx(dd_q, bc_q[i]);
      end

      for (int i = 0; i < 3; i++) begin
        um_q[i] <= u_q[i][UW-1] ? (~u_q[i] + 1'b1) : u_q[i];
      end
      m4_q   <= {abs_a, 1'b0};
      deg4_q <= (a_q == '0);

      // squares of the wide magnitudes split into halves
      for (int i = 0; i < 3; i++) begin
        hh_q[i] <= (2*HI_W)'(um_q[i][UW-1:LO_W]) * (2*HI_W)'(um_q[i][UW-1:LO_W]);
        ll_q[i] <= (2*LO_W)'(um_q[i][LO_W-1:0]) * (2*LO_W)'(um_q[i][LO_W-1:0]);
        hl_q[i] <= (HI_W+LO_W)'(um_q[i][UW-1:LO_W]) * (HI_W+LO_W)'(um_q[i][LO_W-1:0]);
      end
      m5_q   <= m4_q;
      deg5_q <= deg4_q;

      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= (SQU'(hh_q[i]) << (2*LO_W)) + (SQU'(hl_q[i]) << (LO_W+1))
                 + SQU'(ll_q[i]);
      end
      m6_q   <= m5_q;
      deg6_q <= deg5_q;

      job_q.n   <= NW'(sq_q[0]) + NW'(sq_q[1]) + NW'(sq_q[2]);
      job_q.m   <= m6_q;
      job_q.deg <= deg6_q;
    end
  end

endmodule

// ----- rtl/core/tcr_queue.sv -----
`timescale 1ns / 1ps
module tcr_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  tcr_pkg::tcr_job_t  job_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output tcr_pkg::tcr_job_t  job_o
);
  import tcr_pkg::*;

  tcr_job_t          mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (QPTR_W+1)'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= job_i;
  end

endmodule

// ----- rtl/core/tcr_back.sv -----
`timescale 1ns / 1ps
module tcr_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  input  tcr_pkg::tcr_job_t  job_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tcr_pkg::tcr_out_t  out_data_o
);
  import tcr_pkg::*;

  localparam int TOT = RW + RADIUS_W + 3;

  typedef struct packed {
    logic [RW+1:0]  rem;
    logic [RW-1:0]  root;
    logic [NW2-1:0] rad;
    logic [MW-1:0]  m;
    logic           deg;
  } sq_t;

  typedef struct packed {
    logic [MW-1:0]       r;
    logic [RADIUS_W-1:0] num;
    logic [RADIUS_W-1:0] q;
    logic [MW-1:0]       m;
    logic                deg;
    logic                sat;
  } dv_t;

  // one root bit per stage
  function automatic sq_t sq_step(input sq_t s);
    sq_t           o;
    logic [RW+1:0] rm;
    logic [RW+1:0] tr;
    o  = s;
    rm = {s.rem[RW-1:0], s.rad[NW2-1 -: 2]};
    tr = {s.root, 2'b01};
    if (rm >= tr) begin
      o.rem  = rm - tr;
      o.root = {s.root[RW-2:0], 1'b1};
    end else begin
      o.rem  = rm;
      o.root = {s.root[RW-2:0], 1'b0};
    end
    o.rad = s.rad << 2;
    return o;
  endfunction

  function automatic dv_t dv_init(input sq_t s);
    dv_t           o;
    logic [CW-1:0] ext;
    logic [CW-1:0] hi;
    ext   = CW'(s.root);
    hi    = ext >> RADIUS_W;
    o.sat = (hi >= CW'(s.m));
    o.r   = hi[MW-1:0];
    o.num = ext[RADIUS_W-1:0];
    o.q   = '0;
    o.m   = s.m;
    o.deg = s.deg;
    return o;
  endfunction

  // one quotient bit per stage
  function automatic dv_t dv_step(input dv_t s);
    dv_t           o;
    logic [MW:0]   rr;
    logic          bit_q;
    o     = s;
    rr    = {s.r, s.num[RADIUS_W-1]};
    bit_q = (rr >= {1'b0, s.m});
    o.r   = bit_q ? MW'(rr - {1'b0, s.m}) : rr[MW-1:0];
    o.num = s.num << 1;
    o.q   = {s.q[RADIUS_W-2:0], bit_q};
    return o;
  endfunction

  logic           en;
  logic [TOT-1:0] vld_q;
  sq_t            sq_q [RW+1];
  dv_t            dv_q [RADIUS_W+1];
  tcr_out_t       out_q;

  assign en          = !vld_q[TOT-1] || out_ready_i;
  assign pop_o       = en & job_valid_i;
  assign out_valid_o = vld_q[TOT-1];
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[TOT-2:0], job_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q[0].rem  <= '0;
      sq_q[0].root <= '0;
      sq_q[0].rad  <= NW2'(job_i.n) << (2*RADIUS_FRAC_BITS);
      sq_q[0].m    <= job_i.m;
      sq_q[0].deg  <= job_i.deg;
      for (int j = 0; j < RW; j++) begin
        sq_q[j+1] <= sq_step(sq_q[j]);
      end
      dv_q[0] <= dv_init(sq_q[RW]);
      for (int k = 0; k < RADIUS_W; k++) begin
        dv_q[k+1] <= dv_step(dv_q[k]);
      end
      out_q.degenerate <= dv_q[RADIUS_W].deg;
      out_q.saturated  <= !dv_q[RADIUS_W].deg && dv_q[RADIUS_W].sat;
      if (dv_q[RADIUS_W].deg) begin
        out_q.radius <= '0;
      end else if (dv_q[RADIUS_W].sat) begin
        out_q.radius <= '1;
      end else begin
        out_q.radius <= dv_q[RADIUS_W].q;
      end
    end
  end

endmodule

// ----- rtl/core/tetrahedron_circumradius_top.sv -----
`timescale 1ns / 1ps
// tetrahedron circumradius
// in_i carries one request per tetrahedron: four corners as signed grid
// coordinates. out_o returns one result per request, in order: the radius in
// unsigned fixed point with 16 fraction bits (truncated), a degenerate flag for
// coplanar corners (radius 0) and a saturated flag when the radius is clamped.
// throughput: one request per cycle while out_o is taken every cycle.
// a request passes through the 7-stage determinant front end, the request
// queue, the 88-stage square root pipeline (one root bit per stage) and the
// 48-stage divider (one quotient bit per stage) plus the output register (stage
// counts at the default widths).
// a 4-entry queue sits between the front end and the root/divide pipeline;
// when out_o stalls the back pipeline holds, the queue fills and in_i.ready
// drops once it is full.
// reset clears all valid state; no request is in flight afterwards.
module tetrahedron_circumradius_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  tcr_in_if.sink       in_i,
  tcr_out_if.source    out_o
);
  import tcr_pkg::*;

  logic     full, push, pop, q_valid;
  tcr_job_t job_front, job_head;

  tcr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .in_data_i  (in_i.data),
    .full_i     (full),
    .push_o     (push),
    .job_o      (job_front)
  );

  tcr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_front),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .job_o   (job_head)
  );

  tcr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (job_head),
    .pop_o       (pop),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_o.data)
  );

endmodule
